### rtl/core/mmu_pkg.sv
package mmu_pkg;

  localparam int MaxDimDef    = 8;
  localparam int ElemWidthDef = 16;
  localparam int AccW         = 35;
  localparam int DimW         = 4;
  localparam int IdxW         = 3;
  localparam int ValW         = 16;
  localparam int OpW          = 2;
  localparam int CfgIdxW      = 2;
  localparam logic [DimW-1:0] DimReset = 4'd8;

  typedef enum logic [OpW-1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_MUL  = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MAC,
    ST_DRAIN0,
    ST_DRAIN1,
    ST_EMIT,
    ST_ERR
  } step_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_DISPATCH,
    C_K_LOOP,
    C_EMIT
  } cond_e;

  typedef struct packed {
    logic  in_rdy;
    logic  clr_acc;
    logic  issue;
    logic  emit;
    logic  err;
    cond_e cond;
    step_e tgt_t;
    step_e tgt_f;
  } ctrl_t;

  // microcode rom
  function automatic ctrl_t ucode(input step_e step);
    ctrl_t c;
    c = '0;
    c.cond  = C_NEXT;
    c.tgt_t = ST_IDLE;
    c.tgt_f = ST_IDLE;
    case (step)
      ST_IDLE: begin
        c.in_rdy = 1'b1;
        c.cond   = C_DISPATCH;
        c.tgt_t  = ST_ERR;
        c.tgt_f  = ST_START;
      end
      ST_START: begin
        c.clr_acc = 1'b1;
        c.tgt_t   = ST_MAC;
      end
      ST_MAC: begin
        c.issue = 1'b1;
        c.cond  = C_K_LOOP;
        c.tgt_t = ST_MAC;
        c.tgt_f = ST_DRAIN0;
      end
      ST_DRAIN0: begin
        c.tgt_t = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        c.tgt_t = ST_EMIT;
      end
      ST_EMIT: begin
        c.emit  = 1'b1;
        c.cond  = C_EMIT;
        c.tgt_t = ST_IDLE;
        c.tgt_f = ST_START;
      end
      ST_ERR: begin
        c.emit  = 1'b1;
        c.err   = 1'b1;
        c.cond  = C_EMIT;
        c.tgt_t = ST_IDLE;
        c.tgt_f = ST_IDLE;
      end
      default: begin
        c.tgt_t = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

### rtl/core/matrix_multiply_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid_i/in_ready_o  op_i row_i col_i value_i
// out      output     out_valid_o/out_ready_i out_row_o out_col_o out_product_o
//                                             out_last_o out_error_o
// cfg      input      cfg_we_i               cfg_idx_i cfg_data_i
//
// element writes go into a store on acceptance; a multiply produces its result
// elements in turn through the single multiply-accumulate unit fed from one read port
// of each store; a dimension mismatch, once accepted, gives its error result through
// the error step. stores read as zero right after reset with no clearing pass.
// an emit step holds while the output register is full and not taken.
module matrix_multiply_unit #(
  parameter int MAX_DIM    = mmu_pkg::MaxDimDef,
  parameter int ELEM_WIDTH = mmu_pkg::ElemWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmu_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mmu_pkg::DimW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mmu_pkg::OpW-1:0]         op_i,
  input  logic [mmu_pkg::IdxW-1:0]        row_i,
  input  logic [mmu_pkg::IdxW-1:0]        col_i,
  input  logic signed [mmu_pkg::ValW-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mmu_pkg::IdxW-1:0]        out_row_o,
  output logic [mmu_pkg::IdxW-1:0]        out_col_o,
  output logic signed [mmu_pkg::AccW-1:0] out_product_o,
  output logic                            out_last_o,
  output logic                            out_error_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int PW    = 2 * ELEM_WIDTH;

  function automatic logic [DW-1:0] eff_dim(input logic [mmu_pkg::DimW-1:0] r);
    logic [DW-1:0] e;
    if (r == '0) begin
      e = DW'(1);
    end else if (32'(r) > MAX_DIM) begin
      e = DW'(MAX_DIM);
    end else begin
      e = DW'(r);
    end
    return e;
  endfunction

  logic [mmu_pkg::DimW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  mmu_pkg::step_e upc_q, upc_d;
  mmu_pkg::ctrl_t ctl;

  logic [DW-1:0] ar_eff, ac_eff, br_eff, bc_eff;
  logic [IW-1:0] ar_last, ac_last, bc_last;
  logic          mismatch;

  logic [IW-1:0] i_q, j_q, k_q;
  logic          rv_q, pv_q;
  logic signed [PW-1:0]            prod_q;
  logic        [mmu_pkg::AccW-1:0] acc_q;

  logic in_fire, is_mul, in_range, wr_a, wr_b;
  logic out_free, load_out, elem_last, k_more;
  logic [AddrW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic signed [ELEM_WIDTH-1:0] wr_val, rd_a, rd_b;

  logic                     out_valid_q;
  logic [mmu_pkg::IdxW-1:0] out_row_q, out_col_q;
  logic [mmu_pkg::AccW-1:0] out_product_q;
  logic                     out_last_q, out_error_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= mmu_pkg::DimReset;
      a_cols_q <= mmu_pkg::DimReset;
      b_rows_q <= mmu_pkg::DimReset;
      b_cols_q <= mmu_pkg::DimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mmu_pkg::REG_A_ROWS: a_rows_q <= cfg_data_i;
        mmu_pkg::REG_A_COLS: a_cols_q <= cfg_data_i;
        mmu_pkg::REG_B_ROWS: b_rows_q <= cfg_data_i;
        mmu_pkg::REG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ar_eff   = eff_dim(a_rows_q);
    ac_eff   = eff_dim(a_cols_q);
    br_eff   = eff_dim(b_rows_q);
    bc_eff   = eff_dim(b_cols_q);
    ar_last  = IW'(ar_eff - DW'(1));
    ac_last  = IW'(ac_eff - DW'(1));
    bc_last  = IW'(bc_eff - DW'(1));
    mismatch = (ac_eff != br_eff);
  end

  assign ctl = mmu_pkg::ucode(upc_q);

  // control outputs of the current step
  always_comb begin
    in_ready_o = ctl.in_rdy;
    in_fire    = in_valid_i && ctl.in_rdy;
    is_mul     = (op_i == mmu_pkg::OP_MUL);
    in_range   = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
    wr_a       = in_fire && (op_i == mmu_pkg::OP_WR_A) && in_range;
    wr_b       = in_fire && (op_i == mmu_pkg::OP_WR_B) && in_range;
    out_free   = !out_valid_q || out_ready_i;
    load_out   = ctl.emit && out_free;
    elem_last  = (i_q == ar_last) && (j_q == bc_last);
    k_more     = (k_q != ac_last);
  end

  // step sequencing
  always_comb begin
    upc_d = upc_q;
    case (ctl.cond)
      mmu_pkg::C_NEXT: upc_d = ctl.tgt_t;
      mmu_pkg::C_DISPATCH: begin
        if (in_fire && is_mul) begin
          upc_d = mismatch ? ctl.tgt_t : ctl.tgt_f;
        end
      end
      mmu_pkg::C_K_LOOP: upc_d = k_more ? ctl.tgt_t : ctl.tgt_f;
      mmu_pkg::C_EMIT: begin
        if (out_free) begin
          upc_d = (ctl.err || elem_last) ? ctl.tgt_t : ctl.tgt_f;
        end
      end
      default: upc_d = mmu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= mmu_pkg::ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // stores
  assign wr_val    = ELEM_WIDTH'(value_i);
  assign wr_addr   = AddrW'(32'(row_i) * MAX_DIM + 32'(col_i));
  assign rd_addr_a = AddrW'(32'(i_q) * MAX_DIM + 32'(k_q));
  assign rd_addr_b = AddrW'(32'(k_q) * MAX_DIM + 32'(j_q));

  mmu_store #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_store_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_a),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_val),
    .rd_en_i   (ctl.issue),
    .rd_addr_i (rd_addr_a),
    .rd_data_o (rd_a)
  );

  mmu_store #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_store_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_b),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_val),
    .rd_en_i   (ctl.issue),
    .rd_addr_i (rd_addr_b),
    .rd_data_o (rd_b)
  );

  // loop counters and mac pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
      rv_q <= 1'b0;
      pv_q <= 1'b0;
    end else begin
      if (in_fire && is_mul) begin
        i_q <= '0;
        j_q <= '0;
      end else if (load_out && !ctl.err) begin
        if (j_q == bc_last) begin
          j_q <= '0;
          i_q <= IW'(i_q + IW'(1));
        end else begin
          j_q <= IW'(j_q + IW'(1));
        end
      end
      if (ctl.clr_acc) begin
        k_q <= '0;
      end else if (ctl.issue) begin
        k_q <= IW'(k_q + IW'(1));
      end
      rv_q <= ctl.issue;
      pv_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= rd_a * rd_b;
    if (ctl.clr_acc) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + mmu_pkg::AccW'(prod_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_q     <= ctl.err ? '0 : mmu_pkg::IdxW'(i_q);
      out_col_q     <= ctl.err ? '0 : mmu_pkg::IdxW'(j_q);
      out_product_q <= ctl.err ? '0 : acc_q;
      out_last_q    <= ctl.err || elem_last;
      out_error_q   <= ctl.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_product_o = out_product_q;
  assign out_last_o    = out_last_q;
  assign out_error_o   = out_error_q;

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_error_o |-> out_last_o && out_product_o == '0 &&
      out_row_o == '0 && out_col_o == '0)
    else $error("error transaction carries nonzero fields");

  a_mac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q == mmu_pkg::ST_MAC |-> k_q <= ac_last)
    else $error("inner index past a_cols");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q == mmu_pkg::ST_EMIT |-> !rv_q && !pv_q)
    else $error("emit before mac pipeline drained");

  a_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_mul && mismatch |=> upc_q == mmu_pkg::ST_ERR)
    else $error("mismatched multiply did not take error path");

endmodule

### rtl/core/mmu_store.sv
module mmu_store #(
  parameter int MAX_DIM    = mmu_pkg::MaxDimDef,
  parameter int ELEM_WIDTH = mmu_pkg::ElemWidthDef,
  localparam int Depth     = MAX_DIM * MAX_DIM,
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  logic [ELEM_WIDTH-1:0] wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  output logic [ELEM_WIDTH-1:0] rd_data_o
);

  logic [ELEM_WIDTH-1:0] mem_q [Depth];
  logic [Depth-1:0]      vld_q;
  logic [ELEM_WIDTH-1:0] rdata_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

### verif/tb_matrix_multiply_unit.sv
module tb_matrix_multiply_unit;

  localparam int MaxDim = mmu_pkg::MaxDimDef;
  localparam int RandomItems = 420;
  localparam int CycleLimit = 1000000;
  localparam int IdleCycles = 12;
  localparam logic [mmu_pkg::OpW-1:0] OpNone = 2'd3;

  typedef struct packed {
    logic [mmu_pkg::OpW-1:0] op;
    logic [mmu_pkg::IdxW-1:0] row;
    logic [mmu_pkg::IdxW-1:0] col;
    logic signed [mmu_pkg::ValW-1:0] value;
  } elem_req_t;

  typedef struct packed {
    logic [mmu_pkg::IdxW-1:0] row;
    logic [mmu_pkg::IdxW-1:0] col;
    logic signed [mmu_pkg::AccW-1:0] product;
    logic last;
    logic error;
  } elem_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mmu_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [mmu_pkg::DimW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [mmu_pkg::OpW-1:0] op_i = '0;
  logic [mmu_pkg::IdxW-1:0] row_i = '0;
  logic [mmu_pkg::IdxW-1:0] col_i = '0;
  logic signed [mmu_pkg::ValW-1:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [mmu_pkg::IdxW-1:0] out_row_o;
  logic [mmu_pkg::IdxW-1:0] out_col_o;
  logic signed [mmu_pkg::AccW-1:0] out_product_o;
  logic out_last_o;
  logic out_error_o;

  logic steady = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  int issued = 0;

  elem_req_t pending_reqs[$];
  elem_res_t expected_elems[$];
  elem_req_t held_req;

  // predictor state
  logic signed [mmu_pkg::ValW-1:0] mat_a[MaxDim*MaxDim];
  logic signed [mmu_pkg::ValW-1:0] mat_b[MaxDim*MaxDim];
  logic [mmu_pkg::DimW-1:0] dim_ar = mmu_pkg::DimReset;
  logic [mmu_pkg::DimW-1:0] dim_ac = mmu_pkg::DimReset;
  logic [mmu_pkg::DimW-1:0] dim_br = mmu_pkg::DimReset;
  logic [mmu_pkg::DimW-1:0] dim_bc = mmu_pkg::DimReset;

  matrix_multiply_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .out_product_o (out_product_o),
    .out_last_o    (out_last_o),
    .out_error_o   (out_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int eff_dim(input logic [mmu_pkg::DimW-1:0] d);
    if (d == '0) return 1;
    if (32'(d) > MaxDim) return MaxDim;
    return 32'(d);
  endfunction

  function automatic void apply_request(input elem_req_t r);
    int ar;
    int ac;
    int br;
    int bc;
    longint acc;
    elem_res_t res;
    ar = eff_dim(dim_ar);
    ac = eff_dim(dim_ac);
    br = eff_dim(dim_br);
    bc = eff_dim(dim_bc);
    case (r.op)
      mmu_pkg::OP_WR_A: mat_a[int'(r.row) * MaxDim + int'(r.col)] = r.value;
      mmu_pkg::OP_WR_B: mat_b[int'(r.row) * MaxDim + int'(r.col)] = r.value;
      mmu_pkg::OP_MUL: begin
        if (ac != br) begin
          res = '0;
          res.last = 1'b1;
          res.error = 1'b1;
          expected_elems.push_back(res);
        end else begin
          for (int i = 0; i < ar; i++) begin
            for (int j = 0; j < bc; j++) begin
              acc = 0;
              for (int k = 0; k < ac; k++)
                acc += longint'(mat_a[i * MaxDim + k]) * longint'(mat_b[k * MaxDim + j]);
              res.row = mmu_pkg::IdxW'(i);
              res.col = mmu_pkg::IdxW'(j);
              res.product = acc[mmu_pkg::AccW-1:0];
              res.last = (i == ar - 1) && (j == bc - 1);
              res.error = 1'b0;
              expected_elems.push_back(res);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic push_req(input logic [mmu_pkg::OpW-1:0] op, input int row, input int col,
                          input logic signed [mmu_pkg::ValW-1:0] value);
    elem_req_t r;
    r.op = op;
    r.row = mmu_pkg::IdxW'(row);
    r.col = mmu_pkg::IdxW'(col);
    r.value = value;
    pending_reqs.push_back(r);
    if (op != OpNone) issued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_elems.size() != 0);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [mmu_pkg::DimW-1:0] ar,
                          input logic [mmu_pkg::DimW-1:0] ac,
                          input logic [mmu_pkg::DimW-1:0] br,
                          input logic [mmu_pkg::DimW-1:0] bc);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= mmu_pkg::REG_A_ROWS;
    cfg_data_i <= ar;
    @(posedge clk_i);
    cfg_idx_i <= mmu_pkg::REG_A_COLS;
    cfg_data_i <= ac;
    @(posedge clk_i);
    cfg_idx_i <= mmu_pkg::REG_B_ROWS;
    cfg_data_i <= br;
    @(posedge clk_i);
    cfg_idx_i <= mmu_pkg::REG_B_COLS;
    cfg_data_i <= bc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender: one transaction per accept, valid held until taken
  always @(posedge clk_i) begin : drive
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mmu_pkg::REG_A_ROWS: dim_ar = cfg_data_i;
          mmu_pkg::REG_A_COLS: dim_ac = cfg_data_i;
          mmu_pkg::REG_B_ROWS: dim_br = cfg_data_i;
          mmu_pkg::REG_B_COLS: dim_bc = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) apply_request(held_req);
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
          held_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          op_i <= held_req.op;
          row_i <= held_req.row;
          col_i <= held_req.col;
          value_i <= held_req.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    elem_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row %0d col %0d product %0d last %0b error %0b",
                   out_row_o, out_col_o, out_product_o, out_last_o, out_error_o);
      end else begin
        want = expected_elems.pop_front();
        if (out_row_o !== want.row || out_col_o !== want.col ||
            out_product_o !== want.product || out_last_o !== want.last ||
            out_error_o !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp row %0d col %0d product %0d last %0b error %0b, %s",
                     want.row, want.col, want.product, want.last, want.error,
                     $sformatf("got row %0d col %0d product %0d last %0b error %0b",
                               out_row_o, out_col_o, out_product_o, out_last_o,
                               out_error_o));
        end
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= 21);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [mmu_pkg::DimW-1:0] ar;
    logic [mmu_pkg::DimW-1:0] ac;
    logic [mmu_pkg::DimW-1:0] br;
    logic [mmu_pkg::DimW-1:0] bc;
    logic [mmu_pkg::OpW-1:0] op;
    logic signed [mmu_pkg::ValW-1:0] value;
    int unsigned mode;
    int rlim;
    int clim;
    int phase;
    for (int i = 0; i < MaxDim * MaxDim; i++) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // largest sums at full size, stores otherwise zero
    push_req(OpNone, 7, 7, -16'sd1);
    for (int k = 0; k < MaxDim; k++) push_req(mmu_pkg::OP_WR_A, 0, k, -16'sd32768);
    for (int k = 0; k < MaxDim; k++) push_req(mmu_pkg::OP_WR_B, k, 0, -16'sd32768);
    push_req(mmu_pkg::OP_WR_A, 7, 7, 16'sd32767);
    push_req(mmu_pkg::OP_WR_B, 7, 7, 16'sd32767);
    push_req(mmu_pkg::OP_MUL, 0, 0, '0);

    // smallest size, and a write outside it kept for later
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    push_req(mmu_pkg::OP_WR_A, 7, 0, 16'sd100);
    push_req(mmu_pkg::OP_MUL, 0, 0, '0);

    // zero acts as one, above range acts as full size
    set_dims(4'd8, 4'd0, 4'd15, 4'd8);
    push_req(mmu_pkg::OP_MUL, 0, 0, '0);
    set_dims(4'd15, 4'd15, 4'd8, 4'd15);
    push_req(mmu_pkg::OP_MUL, 0, 0, '0);

    issued = 0;
    phase = 0;
    while (issued < RandomItems) begin
      phase++;
      mode = $urandom_range(99);
      if (mode < 70) begin
        ar = mmu_pkg::DimW'($urandom_range(1, 4));
        ac = mmu_pkg::DimW'($urandom_range(1, 4));
        bc = mmu_pkg::DimW'($urandom_range(1, 4));
      end else if (mode < 85) begin
        ar = mmu_pkg::DimW'($urandom_range(5, 8));
        ac = mmu_pkg::DimW'($urandom_range(5, 8));
        bc = mmu_pkg::DimW'($urandom_range(5, 8));
      end else begin
        ar = mmu_pkg::DimW'($urandom_range(15));
        ac = mmu_pkg::DimW'($urandom_range(15));
        bc = mmu_pkg::DimW'($urandom_range(15));
      end
      br = ($urandom_range(99) < 80) ? ac : mmu_pkg::DimW'($urandom_range(15));
      set_dims(ar, ac, br, bc);
      steady <= (phase >= 6 && phase < 9);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(1, 10)) begin
          op = $urandom_range(1) ? mmu_pkg::OP_WR_B : mmu_pkg::OP_WR_A;
          rlim = (op == mmu_pkg::OP_WR_A) ? eff_dim(ar) : eff_dim(br);
          clim = (op == mmu_pkg::OP_WR_A) ? eff_dim(ac) : eff_dim(bc);
          if ($urandom_range(99) >= 85) begin
            rlim = MaxDim;
            clim = MaxDim;
          end
          case ($urandom_range(9))
            0: value = -16'sd32768;
            1: value = 16'sd32767;
            2: value = -16'sd1;
            default: value = mmu_pkg::ValW'($urandom);
          endcase
          push_req(op, $urandom_range(rlim - 1), $urandom_range(clim - 1), value);
          if ($urandom_range(99) < 5)
            push_req(OpNone, $urandom_range(7), $urandom_range(7),
                     mmu_pkg::ValW'($urandom));
        end
        push_req(mmu_pkg::OP_MUL, $urandom_range(7), $urandom_range(7),
                 mmu_pkg::ValW'($urandom));
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/mmu_pkg.sv
rtl/core/mmu_store.sv
rtl/core/matrix_multiply_unit.sv
verif/tb_matrix_multiply_unit.sv
